/* rtl/core/sfcf_pkg.sv */
// Shared types, codes and the microcode table of the SPI flash command framer.
// No dependencies; imported by the framer core, its sequencer and its checker.
`timescale 1ns / 1ps

package sfcf_pkg;

	// Payload field widths
	localparam int CMD_W     = 3;
	localparam int UNIT_W    = 24;
	localparam int OFFSET_W  = 12;
	localparam int LEN_W     = 13;
	localparam int OPCODE_W  = 8;
	localparam int ADDR_W    = 32;
	localparam int ABYTES_W  = 3;
	localparam int COUNT_W   = 9;

	// Frames per sector request at most
	localparam int FRAME_CAP = 16;
	localparam int FRAME_N_W = $clog2(FRAME_CAP);

	// Request commands
	localparam logic [CMD_W-1:0] CMD_READ_PAGE    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PROG_PAGE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ_SECTOR  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PROG_SECTOR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ERASE_SECTOR = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ERASE_BLOCK  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_ERASE_CHIP   = 3'd6;

	// Flash instruction bytes
	localparam logic [OPCODE_W-1:0] OP_NONE         = 8'h00;
	localparam logic [OPCODE_W-1:0] OP_READ         = 8'h0B;
	localparam logic [OPCODE_W-1:0] OP_PROGRAM      = 8'h02;
	localparam logic [OPCODE_W-1:0] OP_ERASE_SECTOR = 8'h20;
	localparam logic [OPCODE_W-1:0] OP_ERASE_BLOCK  = 8'hD8;
	localparam logic [OPCODE_W-1:0] OP_ERASE_CHIP   = 8'hC7;

	// Address sizes
	localparam logic [ABYTES_W-1:0] ABYTES_NONE  = 3'd0;
	localparam logic [ABYTES_W-1:0] ABYTES_THREE = 3'd3;
	localparam logic [ABYTES_W-1:0] ABYTES_FOUR  = 3'd4;

	// Datapath action of one microcode step
	typedef enum logic [2:0] {
		ACT_WAIT_IN,
		ACT_DISPATCH,
		ACT_SETUP,
		ACT_ADD_OFF,
		ACT_EMIT
	} act_t;

	// How the step counter moves
	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_ACCEPT,
		COND_DISPATCH,
		COND_LAST_SENT
	} cond_t;

	// Unit size for the address multiply and the length clamp
	typedef enum logic [1:0] {
		MUL_PAGE,
		MUL_SECTOR,
		MUL_BLOCK
	} mul_t;

	// Kind of frame an emit step produces
	typedef enum logic [2:0] {
		KIND_READ,
		KIND_PROG,
		KIND_ERASE_SECTOR,
		KIND_ERASE_BLOCK,
		KIND_ERASE_CHIP,
		KIND_REJECT
	} kind_t;

	typedef logic [4:0] step_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		mul_t  mul;
		kind_t kind;
		step_t next;
	} ctl_word_t;

	// Status from the datapath back to the sequencer
	typedef struct packed {
		logic  accepted;
		logic  emitted;
		logic  emit_last;
		step_t dispatch_step;
	} seq_status_t;

	// Program entry points
	localparam step_t STEP_WAIT     = 5'd0;
	localparam step_t STEP_DISPATCH = 5'd1;
	localparam step_t STEP_PR_SETUP = 5'd2;
	localparam step_t STEP_PR_ADD   = 5'd3;
	localparam step_t STEP_PR_EMIT  = 5'd4;
	localparam step_t STEP_PP_SETUP = 5'd5;
	localparam step_t STEP_PP_ADD   = 5'd6;
	localparam step_t STEP_PP_EMIT  = 5'd7;
	localparam step_t STEP_SR_SETUP = 5'd8;
	localparam step_t STEP_SR_ADD   = 5'd9;
	localparam step_t STEP_SR_EMIT  = 5'd10;
	localparam step_t STEP_SP_SETUP = 5'd11;
	localparam step_t STEP_SP_ADD   = 5'd12;
	localparam step_t STEP_SP_EMIT  = 5'd13;
	localparam step_t STEP_ES_SETUP = 5'd14;
	localparam step_t STEP_ES_EMIT  = 5'd15;
	localparam step_t STEP_EB_SETUP = 5'd16;
	localparam step_t STEP_EB_EMIT  = 5'd17;
	localparam step_t STEP_EC_EMIT  = 5'd18;
	localparam step_t STEP_REJ_EMIT = 5'd19;

	// Microcode table: one control word per step
	function automatic ctl_word_t ucode_rom(input step_t s);
		ctl_word_t w;
		w = '{act: ACT_WAIT_IN, cond: COND_ACCEPT, mul: MUL_PAGE, kind: KIND_REJECT,
			next: STEP_DISPATCH};
		case (s)
			STEP_WAIT: w = '{act: ACT_WAIT_IN, cond: COND_ACCEPT, mul: MUL_PAGE,
				kind: KIND_REJECT, next: STEP_DISPATCH};
			STEP_DISPATCH: w = '{act: ACT_DISPATCH, cond: COND_DISPATCH, mul: MUL_PAGE,
				kind: KIND_REJECT, next: STEP_WAIT};
			STEP_PR_SETUP: w = '{act: ACT_SETUP, cond: COND_ALWAYS, mul: MUL_PAGE,
				kind: KIND_READ, next: STEP_PR_ADD};
			STEP_PR_ADD: w = '{act: ACT_ADD_OFF, cond: COND_ALWAYS, mul: MUL_PAGE,
				kind: KIND_READ, next: STEP_PR_EMIT};
			STEP_PR_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_PAGE,
				kind: KIND_READ, next: STEP_WAIT};
			STEP_PP_SETUP: w = '{act: ACT_SETUP, cond: COND_ALWAYS, mul: MUL_PAGE,
				kind: KIND_PROG, next: STEP_PP_ADD};
			STEP_PP_ADD: w = '{act: ACT_ADD_OFF, cond: COND_ALWAYS, mul: MUL_PAGE,
				kind: KIND_PROG, next: STEP_PP_EMIT};
			STEP_PP_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_PAGE,
				kind: KIND_PROG, next: STEP_WAIT};
			STEP_SR_SETUP: w = '{act: ACT_SETUP, cond: COND_ALWAYS, mul: MUL_SECTOR,
				kind: KIND_READ, next: STEP_SR_ADD};
			STEP_SR_ADD: w = '{act: ACT_ADD_OFF, cond: COND_ALWAYS, mul: MUL_SECTOR,
				kind: KIND_READ, next: STEP_SR_EMIT};
			STEP_SR_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_SECTOR,
				kind: KIND_READ, next: STEP_WAIT};
			STEP_SP_SETUP: w = '{act: ACT_SETUP, cond: COND_ALWAYS, mul: MUL_SECTOR,
				kind: KIND_PROG, next: STEP_SP_ADD};
			STEP_SP_ADD: w = '{act: ACT_ADD_OFF, cond: COND_ALWAYS, mul: MUL_SECTOR,
				kind: KIND_PROG, next: STEP_SP_EMIT};
			STEP_SP_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_SECTOR,
				kind: KIND_PROG, next: STEP_WAIT};
			STEP_ES_SETUP: w = '{act: ACT_SETUP, cond: COND_ALWAYS, mul: MUL_SECTOR,
				kind: KIND_ERASE_SECTOR, next: STEP_ES_EMIT};
			STEP_ES_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_SECTOR,
				kind: KIND_ERASE_SECTOR, next: STEP_WAIT};
			STEP_EB_SETUP: w = '{act: ACT_SETUP, cond: COND_ALWAYS, mul: MUL_BLOCK,
				kind: KIND_ERASE_BLOCK, next: STEP_EB_EMIT};
			STEP_EB_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_BLOCK,
				kind: KIND_ERASE_BLOCK, next: STEP_WAIT};
			STEP_EC_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_PAGE,
				kind: KIND_ERASE_CHIP, next: STEP_WAIT};
			STEP_REJ_EMIT: w = '{act: ACT_EMIT, cond: COND_LAST_SENT, mul: MUL_PAGE,
				kind: KIND_REJECT, next: STEP_WAIT};
			default: w = '{act: ACT_WAIT_IN, cond: COND_ALWAYS, mul: MUL_PAGE,
				kind: KIND_REJECT, next: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/spi_flash_command_framer_core.sv */
// Top level of the SPI flash command framer: request latch, address and length
// datapath, frame output register. Depends on sfcf_pkg and sfcf_sequencer.
`timescale 1ns / 1ps

// Usage
//   Request channel (in_valid / in_stall): one flash request per transfer,
//   taken only while the sequencer waits for work; in_stall is high otherwise.
//   Frame channel (out_valid / out_stall): one frame descriptor per transfer,
//   held in an output register; out_stall holds it and pauses the sequencer.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   four_byte_addressing only while no request is in flight.
// Sequencing
//   A taken request runs the dispatch step, then setup and offset add for a
//   page or sector transfer, setup alone for a sector or block erase, and
//   neither for chip erase or a rejected request, before the emit step.
//   The emit step registers each frame, up to 16 page frames per sector
//   transfer, one frame per cycle while the frame channel does not stall.
//   The next request is taken while the last frame still waits downstream.
// Reset
//   The step counter returns to the wait step, the frame register empties
//   and four_byte_addressing clears to 0. No clearing pass is needed.

module spi_flash_command_framer_core #(
	parameter int PAGE_BYTES        = 256,
	parameter int SECTOR_BYTES      = 4096,
	parameter int SECTORS_PER_BLOCK = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sfcf_pkg::CMD_W-1:0]        command,
	input  logic [sfcf_pkg::UNIT_W-1:0]       unit_index,
	input  logic [sfcf_pkg::OFFSET_W-1:0]     offset,
	input  logic [sfcf_pkg::LEN_W-1:0]        length,
	// frame channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sfcf_pkg::OPCODE_W-1:0]     opcode,
	output logic [sfcf_pkg::ADDR_W-1:0]       address,
	output logic [sfcf_pkg::ABYTES_W-1:0]     address_bytes,
	output logic                              dummy_bytes,
	output logic [sfcf_pkg::COUNT_W-1:0]      payload_count,
	output logic                              payload_is_read,
	output logic                              write_enable_first,
	output logic                              wait_idle_before,
	output logic                              wait_idle_after,
	output logic                              rejected,
	output logic                              last,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data
);
	import sfcf_pkg::*;

	localparam int BLOCK_SPAN = SECTOR_BYTES * SECTORS_PER_BLOCK;
	localparam int MUL_W      = $clog2(BLOCK_SPAN + 1);
	localparam int PROD_W     = UNIT_W + MUL_W;
	localparam int PAGE_W     = $clog2(PAGE_BYTES);
	localparam int ROOM_W     = $clog2(PAGE_BYTES + 1);
	localparam int SPAN_W     = ($clog2(SECTOR_BYTES + 1) > ROOM_W) ?
		$clog2(SECTOR_BYTES + 1) : ROOM_W;
	localparam int REM_W      = (SPAN_W > LEN_W) ? SPAN_W : LEN_W;
	localparam int Q_BITS     = $clog2((1 << OFFSET_W) / PAGE_BYTES + 1);
	localparam int MOD_W      = OFFSET_W + 2;

	// Offset modulo the page size, one restoring step per quotient bit
	function automatic logic [PAGE_W-1:0] page_rem(input logic [OFFSET_W-1:0] v);
		logic [MOD_W-1:0] r;
		r = MOD_W'(v);
		for (int k = Q_BITS - 1; k >= 0; k--) begin
			if (r >= (MOD_W'(PAGE_BYTES) << k)) begin
				r = r - (MOD_W'(PAGE_BYTES) << k);
			end
		end
		return PAGE_W'(r);
	endfunction

	ctl_word_t   ctl;
	seq_status_t status;

	// request latch and working registers
	logic [CMD_W-1:0]     cmd_q;
	logic [UNIT_W-1:0]    unit_q;
	logic [OFFSET_W-1:0]  off_q;
	logic [LEN_W-1:0]     len_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [REM_W-1:0]     remaining_q;
	logic [PAGE_W-1:0]    local_q;
	logic [FRAME_N_W-1:0] n_q;
	logic                 fba_q;

	// frame output register
	logic                 out_valid_q;
	logic [OPCODE_W-1:0]  opcode_q;
	logic [ADDR_W-1:0]    address_q;
	logic [ABYTES_W-1:0]  address_bytes_q;
	logic                 dummy_bytes_q;
	logic [COUNT_W-1:0]   payload_count_q;
	logic                 payload_is_read_q;
	logic                 write_enable_first_q;
	logic                 wait_idle_before_q;
	logic                 wait_idle_after_q;
	logic                 rejected_q;
	logic                 last_q;

	logic                 accept;
	logic                 slot_free;
	logic                 fire;
	step_t                dispatch_step;
	logic [MUL_W-1:0]     mul_k;
	logic [PROD_W-1:0]    prod;
	logic [REM_W-1:0]     span;
	logic [REM_W-1:0]     len_w;
	logic [REM_W-1:0]     off_w;
	logic [REM_W-1:0]     len_eff;
	logic [REM_W-1:0]     lim;
	logic [REM_W-1:0]     setup_rem;
	logic [PAGE_W-1:0]    setup_local;
	logic [ROOM_W-1:0]    room;
	logic [REM_W-1:0]     count;
	logic [REM_W-1:0]     rem_next;
	logic                 data_last;
	logic [ABYTES_W-1:0]  ab_cfg;

	// frame fields being built
	logic [OPCODE_W-1:0]  f_opcode;
	logic [ADDR_W-1:0]    f_address;
	logic [ABYTES_W-1:0]  f_abytes;
	logic                 f_dummy;
	logic [COUNT_W-1:0]   f_count;
	logic                 f_rd;
	logic                 f_we;
	logic                 f_wb;
	logic                 f_wa;
	logic                 f_rej;
	logic                 f_last;

	sfcf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	// Handshakes
	assign in_stall  = (ctl.act != ACT_WAIT_IN);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign fire      = (ctl.act == ACT_EMIT) && slot_free;
	assign cfg_ready = 1'b1;

	// Route the request to its program, or to the reject frame
	always_comb begin
		case (cmd_q)
			CMD_READ_PAGE:
				dispatch_step = (REM_W'(off_q) >= REM_W'(PAGE_BYTES)) ? STEP_REJ_EMIT
					: STEP_PR_SETUP;
			CMD_PROG_PAGE:
				dispatch_step = (REM_W'(off_q) >= REM_W'(PAGE_BYTES)) ? STEP_REJ_EMIT
					: STEP_PP_SETUP;
			CMD_READ_SECTOR:
				dispatch_step = (REM_W'(off_q) >= REM_W'(SECTOR_BYTES)) ? STEP_REJ_EMIT
					: STEP_SR_SETUP;
			CMD_PROG_SECTOR:
				dispatch_step = (REM_W'(off_q) >= REM_W'(SECTOR_BYTES)) ? STEP_REJ_EMIT
					: STEP_SP_SETUP;
			CMD_ERASE_SECTOR: dispatch_step = STEP_ES_SETUP;
			CMD_ERASE_BLOCK:  dispatch_step = STEP_EB_SETUP;
			CMD_ERASE_CHIP:   dispatch_step = STEP_EC_EMIT;
			default:          dispatch_step = STEP_REJ_EMIT;
		endcase
	end

	// Base address multiply by the selected unit size
	always_comb begin
		case (ctl.mul)
			MUL_PAGE:   mul_k = MUL_W'(PAGE_BYTES);
			MUL_SECTOR: mul_k = MUL_W'(SECTOR_BYTES);
			MUL_BLOCK:  mul_k = MUL_W'(BLOCK_SPAN);
			default:    mul_k = '0;
		endcase
	end
	assign prod = PROD_W'(unit_q) * PROD_W'(mul_k);

	// Clamp the length to the rest of the page or sector
	always_comb begin
		span    = (ctl.mul == MUL_PAGE) ? REM_W'(PAGE_BYTES) : REM_W'(SECTOR_BYTES);
		len_w   = REM_W'(len_q);
		off_w   = REM_W'(off_q);
		len_eff = ((len_w == '0) || (len_w > span)) ? span : len_w;
		lim     = span - off_w;
		setup_rem   = (len_eff < lim) ? len_eff : lim;
		setup_local = (ctl.mul == MUL_PAGE) ? PAGE_W'(off_q) : page_rem(off_q);
	end

	// Split the range at page boundaries
	always_comb begin
		room      = ROOM_W'(PAGE_BYTES) - ROOM_W'(local_q);
		count     = (remaining_q < REM_W'(room)) ? remaining_q : REM_W'(room);
		rem_next  = remaining_q - count;
		data_last = (rem_next == '0) || (n_q == FRAME_N_W'(FRAME_CAP - 1));
		ab_cfg    = fba_q ? ABYTES_FOUR : ABYTES_THREE;
	end

	// Build the frame fields of the current kind
	always_comb begin
		f_opcode  = OP_NONE;
		f_address = addr_q;
		f_abytes  = ab_cfg;
		f_dummy   = 1'b0;
		f_count   = '0;
		f_rd      = 1'b0;
		f_we      = 1'b1;
		f_wb      = 1'b1;
		f_wa      = 1'b1;
		f_rej     = 1'b0;
		f_last    = 1'b1;
		case (ctl.kind)
			KIND_READ: begin
				f_opcode = OP_READ;
				f_dummy  = 1'b1;
				f_count  = COUNT_W'(count);
				f_rd     = 1'b1;
				f_we     = 1'b0;
				f_wb     = 1'b0;
				f_wa     = 1'b0;
				f_last   = data_last;
			end
			KIND_PROG: begin
				f_opcode = OP_PROGRAM;
				f_count  = COUNT_W'(count);
				f_last   = data_last;
			end
			KIND_ERASE_SECTOR: f_opcode = OP_ERASE_SECTOR;
			KIND_ERASE_BLOCK:  f_opcode = OP_ERASE_BLOCK;
			KIND_ERASE_CHIP: begin
				f_opcode  = OP_ERASE_CHIP;
				f_address = '0;
				f_abytes  = ABYTES_NONE;
				f_wb      = 1'b0;
			end
			default: begin
				f_address = '0;
				f_abytes  = ABYTES_NONE;
				f_we      = 1'b0;
				f_wb      = 1'b0;
				f_wa      = 1'b0;
				f_rej     = 1'b1;
			end
		endcase
	end

	// Report to the sequencer
	always_comb begin
		status.accepted      = accept;
		status.emitted       = fire;
		status.emit_last     = f_last;
		status.dispatch_step = dispatch_step;
	end

	// Hold control state: config register and frame valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fba_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fba_q <= cfg_data;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the request and advance the working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			unit_q <= unit_index;
			off_q  <= offset;
			len_q  <= length;
		end
		case (ctl.act)
			ACT_SETUP: begin
				addr_q      <= prod[ADDR_W-1:0];
				remaining_q <= setup_rem;
				local_q     <= setup_local;
				n_q         <= '0;
			end
			ACT_ADD_OFF: begin
				addr_q <= addr_q + ADDR_W'(off_q);
			end
			ACT_EMIT: begin
				if (fire) begin
					addr_q      <= addr_q + ADDR_W'(count);
					remaining_q <= rem_next;
					local_q     <= '0;
					n_q         <= n_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Load the frame register when the slot frees
	always_ff @(posedge clk) begin
		if (fire) begin
			opcode_q             <= f_opcode;
			address_q            <= f_address;
			address_bytes_q      <= f_abytes;
			dummy_bytes_q        <= f_dummy;
			payload_count_q      <= f_count;
			payload_is_read_q    <= f_rd;
			write_enable_first_q <= f_we;
			wait_idle_before_q   <= f_wb;
			wait_idle_after_q    <= f_wa;
			rejected_q           <= f_rej;
			last_q               <= f_last;
		end
	end

	assign out_valid          = out_valid_q;
	assign opcode             = opcode_q;
	assign address            = address_q;
	assign address_bytes      = address_bytes_q;
	assign dummy_bytes        = dummy_bytes_q;
	assign payload_count      = payload_count_q;
	assign payload_is_read    = payload_is_read_q;
	assign write_enable_first = write_enable_first_q;
	assign wait_idle_before   = wait_idle_before_q;
	assign wait_idle_after    = wait_idle_after_q;
	assign rejected           = rejected_q;
	assign last               = last_q;

endmodule

/* rtl/core/sfcf_sequencer.sv */
// Step counter and microcode fetch of the SPI flash command framer.
// Depends on sfcf_pkg for the control word, status struct and program table.
`timescale 1ns / 1ps

module sfcf_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  sfcf_pkg::seq_status_t status,
	output sfcf_pkg::ctl_word_t ctl
);
	import sfcf_pkg::*;

	step_t step_q;
	step_t step_d;

	// Fetch the control word of the current step
	assign ctl = ucode_rom(step_q);

	// Pick the next step by the jump condition
	always_comb begin
		case (ctl.cond)
			COND_ALWAYS:    step_d = ctl.next;
			COND_ACCEPT:    step_d = status.accepted ? ctl.next : step_q;
			COND_DISPATCH:  step_d = status.dispatch_step;
			COND_LAST_SENT: step_d = (status.emitted && status.emit_last) ? ctl.next : step_q;
			default:        step_d = STEP_WAIT;
		endcase
	end

	// Hold the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

/* rtl/core/sfcf_checker.sv */
// Port-level checker for the SPI flash command framer, bound to the top level.
// Depends on sfcf_pkg for field widths and opcodes.
`timescale 1ns / 1ps

module sfcf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [sfcf_pkg::OPCODE_W-1:0]     opcode,
	input logic [sfcf_pkg::ADDR_W-1:0]       address,
	input logic [sfcf_pkg::ABYTES_W-1:0]     address_bytes,
	input logic [sfcf_pkg::COUNT_W-1:0]      payload_count,
	input logic                              write_enable_first,
	input logic                              wait_idle_before,
	input logic                              wait_idle_after,
	input logic                              rejected,
	input logic                              last
);
	import sfcf_pkg::*;

	// A taken request keeps the request side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while the previous one was still starting");

	// A rejected frame is a bare final marker
	a_reject_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> (last && opcode == OP_NONE && address == '0
			&& payload_count == '0 && !write_enable_first && !wait_idle_after))
		else $error("rejected frame carries frame content");

	// Chip erase sends no address and needs no idle wait before
	a_chip_erase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && opcode == OP_ERASE_CHIP) |-> (address_bytes == ABYTES_NONE
			&& address == '0 && !wait_idle_before && last && write_enable_first))
		else $error("chip erase frame malformed");

	// A stalled frame stays in place
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(address)
			&& $stable(payload_count) && $stable(last)))
		else $error("stalled frame changed");

endmodule

bind spi_flash_command_framer_core sfcf_checker u_sfcf_checker (.*);

/* verif/sfcf_tb_pkg.sv */
// Frame descriptor type and expected-frame scoreboard for the framer testbench.
// Depends on sfcf_pkg for field widths, command codes and opcodes.
`timescale 1ns / 1ps

package sfcf_tb_pkg;
	import sfcf_pkg::*;

	// Geometry the block is built with
	localparam int PAGE_BYTES        = 256;
	localparam int SECTOR_BYTES      = 4096;
	localparam int SECTORS_PER_BLOCK = 16;

	// Command code the block does not define
	localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [ADDR_W-1:0]   address;
		logic [ABYTES_W-1:0] address_bytes;
		logic                dummy_bytes;
		logic [COUNT_W-1:0]  payload_count;
		logic                payload_is_read;
		logic                write_enable_first;
		logic                wait_idle_before;
		logic                wait_idle_after;
		logic                rejected;
		logic                last;
	} frame_t;

	class frame_scoreboard;
		frame_t      expected_frames[$];
		bit          four_byte;
		int unsigned requests_seen;
		int unsigned frames_checked;
		int unsigned errors;

		function new();
			four_byte = 1'b0;
			requests_seen = 0;
			frames_checked = 0;
			errors = 0;
		endfunction

		function void set_four_byte(bit v);
			four_byte = v;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		// Read or program frame for one page worth of data
		function frame_t transfer_frame(bit is_read, logic [ADDR_W-1:0] addr,
				int unsigned count, bit is_last);
			frame_t f;
			f = '0;
			f.opcode = is_read ? OP_READ : OP_PROGRAM;
			f.address = addr;
			f.address_bytes = four_byte ? ABYTES_FOUR : ABYTES_THREE;
			f.dummy_bytes = is_read;
			f.payload_count = count[COUNT_W-1:0];
			f.payload_is_read = is_read;
			f.write_enable_first = !is_read;
			f.wait_idle_before = !is_read;
			f.wait_idle_after = !is_read;
			f.last = is_last;
			return f;
		endfunction

		// Erase frame: no payload, always write-enabled and polled after
		function frame_t erase_frame(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] addr,
				bit whole_chip);
			frame_t f;
			f = '0;
			f.opcode = op;
			f.address = addr;
			f.address_bytes = whole_chip ? ABYTES_NONE :
				(four_byte ? ABYTES_FOUR : ABYTES_THREE);
			f.write_enable_first = 1'b1;
			f.wait_idle_before = !whole_chip;
			f.wait_idle_after = 1'b1;
			f.last = 1'b1;
			return f;
		endfunction

		// Expand one accepted request into the frames it must produce
		function void note_request(logic [CMD_W-1:0] cmd, logic [UNIT_W-1:0] unit,
				logic [OFFSET_W-1:0] off, logic [LEN_W-1:0] len);
			frame_t          refused;
			logic [63:0]     base;
			logic [ADDR_W-1:0] addr;
			int unsigned     left;
			int unsigned     room;
			int unsigned     chunk;
			int              n;
			refused = '0;
			refused.rejected = 1'b1;
			refused.last = 1'b1;
			requests_seen++;
			case (cmd)
				CMD_READ_PAGE, CMD_PROG_PAGE: begin
					if (off >= PAGE_BYTES) begin
						expected_frames.push_back(refused);
					end else begin
						left = (len == 0 || len > PAGE_BYTES) ? PAGE_BYTES : len;
						if (off + left > PAGE_BYTES)
							left = PAGE_BYTES - off;
						base = 64'(unit) * PAGE_BYTES + off;
						expected_frames.push_back(transfer_frame(cmd == CMD_READ_PAGE,
							base[ADDR_W-1:0], left, 1'b1));
					end
				end
				CMD_READ_SECTOR, CMD_PROG_SECTOR: begin
					if (off >= SECTOR_BYTES) begin
						expected_frames.push_back(refused);
					end else begin
						left = (len == 0 || len > SECTOR_BYTES) ? SECTOR_BYTES : len;
						if (off + left > SECTOR_BYTES)
							left = SECTOR_BYTES - off;
						base = 64'(unit) * SECTOR_BYTES + off;
						addr = base[ADDR_W-1:0];
						room = PAGE_BYTES - (off % PAGE_BYTES);
						n = 0;
						// Split at page boundaries, first chunk up to the page end
						while (left > 0 && n < FRAME_CAP) begin
							chunk = (left < room) ? left : room;
							left -= chunk;
							expected_frames.push_back(transfer_frame(cmd == CMD_READ_SECTOR,
								addr, chunk, left == 0 || n == FRAME_CAP - 1));
							addr += chunk;
							room = PAGE_BYTES;
							n++;
						end
					end
				end
				CMD_ERASE_SECTOR: begin
					base = 64'(unit) * SECTOR_BYTES;
					expected_frames.push_back(erase_frame(OP_ERASE_SECTOR,
						base[ADDR_W-1:0], 1'b0));
				end
				CMD_ERASE_BLOCK: begin
					base = 64'(unit) * (SECTOR_BYTES * SECTORS_PER_BLOCK);
					expected_frames.push_back(erase_frame(OP_ERASE_BLOCK,
						base[ADDR_W-1:0], 1'b0));
				end
				CMD_ERASE_CHIP: begin
					expected_frames.push_back(erase_frame(OP_ERASE_CHIP, '0, 1'b1));
				end
				default: begin
					expected_frames.push_back(refused);
				end
			endcase
		endfunction

		function void check_field(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			end
		endfunction

		// Compare one delivered frame with the oldest expected one
		function void check_frame(frame_t got);
			frame_t want;
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t: frame with nothing expected, opcode %0h address %0h",
					$time, got.opcode, got.address);
				return;
			end
			want = expected_frames.pop_front();
			frames_checked++;
			check_field("opcode", want.opcode, got.opcode);
			check_field("address", want.address, got.address);
			check_field("address_bytes", want.address_bytes, got.address_bytes);
			check_field("dummy_bytes", want.dummy_bytes, got.dummy_bytes);
			check_field("payload_count", want.payload_count, got.payload_count);
			check_field("payload_is_read", want.payload_is_read, got.payload_is_read);
			check_field("write_enable_first", want.write_enable_first,
				got.write_enable_first);
			check_field("wait_idle_before", want.wait_idle_before, got.wait_idle_before);
			check_field("wait_idle_after", want.wait_idle_after, got.wait_idle_after);
			check_field("rejected", want.rejected, got.rejected);
			check_field("last", want.last, got.last);
		endfunction
	endclass

endpackage

/* verif/tb.sv */
// Testbench top for spi_flash_command_framer_core: drives requests and config
// writes, checks every frame descriptor. Depends on sfcf_pkg and sfcf_tb_pkg.
`timescale 1ns / 1ps

module tb;
	import sfcf_pkg::*;
	import sfcf_tb_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    command;
	logic [UNIT_W-1:0]   unit_index;
	logic [OFFSET_W-1:0] offset;
	logic [LEN_W-1:0]    length;
	logic                out_valid;
	logic                out_stall;
	logic [OPCODE_W-1:0] opcode;
	logic [ADDR_W-1:0]   address;
	logic [ABYTES_W-1:0] address_bytes;
	logic                dummy_bytes;
	logic [COUNT_W-1:0]  payload_count;
	logic                payload_is_read;
	logic                write_enable_first;
	logic                wait_idle_before;
	logic                wait_idle_after;
	logic                rejected;
	logic                last;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_data;

	frame_scoreboard ledger;
	int unsigned     idle_pct;
	int unsigned     stall_pct;

	spi_flash_command_framer_core #(
		.PAGE_BYTES       (PAGE_BYTES),
		.SECTOR_BYTES     (SECTOR_BYTES),
		.SECTORS_PER_BLOCK(SECTORS_PER_BLOCK)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.unit_index        (unit_index),
		.offset            (offset),
		.length            (length),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.opcode            (opcode),
		.address           (address),
		.address_bytes     (address_bytes),
		.dummy_bytes       (dummy_bytes),
		.payload_count     (payload_count),
		.payload_is_read   (payload_is_read),
		.write_enable_first(write_enable_first),
		.wait_idle_before  (wait_idle_before),
		.wait_idle_after   (wait_idle_after),
		.rejected          (rejected),
		.last              (last),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Stall the frame channel at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Check every frame taken from the block
	always @(posedge clk) begin : take_frame
		frame_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.opcode = opcode;
			got.address = address;
			got.address_bytes = address_bytes;
			got.dummy_bytes = dummy_bytes;
			got.payload_count = payload_count;
			got.payload_is_read = payload_is_read;
			got.write_enable_first = write_enable_first;
			got.wait_idle_before = wait_idle_before;
			got.wait_idle_after = wait_idle_after;
			got.rejected = rejected;
			got.last = last;
			ledger.check_frame(got);
		end
	end

	// End the run when no channel moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, quiet);
		$display("spi_flash_command_framer_core: mismatch");
		$finish;
	end

	// Present one request from a falling edge, hold it until taken
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [UNIT_W-1:0] unit,
			logic [OFFSET_W-1:0] off, logic [LEN_W-1:0] len);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		unit_index <= unit;
		offset <= off;
		length <= len;
		do @(posedge clk); while (in_stall);
		ledger.note_request(cmd, unit, off, len);
		@(negedge clk);
	endtask

	// Drop the request line and wait until every expected frame has arrived
	task automatic wait_drained(int unsigned tail);
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// Write four_byte_addressing; the block must be idle
	task automatic write_addr_mode(bit v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_four_byte(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random requests, weighted toward valid offsets and interesting lengths
	task automatic run_random(int count, int pause_at);
		logic [CMD_W-1:0]    cmd;
		logic [UNIT_W-1:0]   unit;
		logic [OFFSET_W-1:0] off;
		logic [LEN_W-1:0]    len;
		int unsigned         pick;
		logic [CMD_W-1:0]    kinds [7];
		kinds = '{CMD_READ_PAGE, CMD_PROG_PAGE, CMD_READ_SECTOR, CMD_PROG_SECTOR,
			CMD_ERASE_SECTOR, CMD_ERASE_BLOCK, CMD_ERASE_CHIP};
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained(0);
			pick = $urandom_range(0, 31);
			cmd = (pick == 0) ? CMD_UNDEFINED : kinds[pick % 7];
			case ($urandom_range(0, 7))
				0: unit = '0;
				1: unit = '1;
				default: unit = UNIT_W'($urandom());
			endcase
			if ((cmd == CMD_READ_PAGE || cmd == CMD_PROG_PAGE) && $urandom_range(0, 9) != 0)
				off = OFFSET_W'($urandom_range(0, PAGE_BYTES - 1));
			else if ($urandom_range(0, 7) == 0)
				off = $urandom_range(0, 1) ? '1 : '0;
			else
				off = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
			case ($urandom_range(0, 11))
				0, 1: len = '0;
				2: len = LEN_W'(SECTOR_BYTES);
				3, 4, 5: len = LEN_W'($urandom_range(1, PAGE_BYTES));
				default: len = LEN_W'($urandom_range(1, SECTOR_BYTES));
			endcase
			send_request(cmd, unit, off, len);
		end
	endtask

	initial begin
		ledger = new();
		idle_pct = 11;
		stall_pct = 11;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_READ_PAGE;
		unit_index = '0;
		offset = '0;
		length = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: three-byte addressing from reset
		send_request(CMD_READ_PAGE, 24'h000000, 12'd0, 13'd0);
		send_request(CMD_PROG_PAGE, 24'hFFFFFF, 12'd255, 13'd4096);
		send_request(CMD_READ_PAGE, 24'h123456, 12'd256, 13'd16);
		send_request(CMD_PROG_PAGE, 24'h000001, 12'd4095, 13'd1);
		send_request(CMD_READ_PAGE, 24'h00ABCD, 12'd10, 13'd300);
		send_request(CMD_PROG_PAGE, 24'h5A5A5A, 12'd100, 13'd100);
		send_request(CMD_PROG_PAGE, 24'hA5A5A5, 12'd200, 13'd100);
		send_request(CMD_READ_SECTOR, 24'h000000, 12'd0, 13'd0);
		send_request(CMD_PROG_SECTOR, 24'hFFFFFF, 12'd4095, 13'd4096);
		send_request(CMD_READ_SECTOR, 24'h000777, 12'd300, 13'd5);
		send_request(CMD_PROG_SECTOR, 24'h000042, 12'd250, 13'd20);
		send_request(CMD_READ_SECTOR, 24'h0FFFFF, 12'd17, 13'd4096);
		send_request(CMD_ERASE_SECTOR, 24'hFFFFFF, 12'd0, 13'd0);
		send_request(CMD_ERASE_BLOCK, 24'hFFFFFF, 12'd0, 13'd0);
		send_request(CMD_ERASE_CHIP, 24'hFFFFFF, 12'hFFF, 13'd4096);
		send_request(CMD_UNDEFINED, 24'h00FF00, 12'd0, 13'd0);
		send_request(CMD_READ_SECTOR, 24'h000010, 12'd4095, 13'd1);
		wait_drained(8);

		// Directed: four-byte addressing
		write_addr_mode(1'b1);
		send_request(CMD_READ_PAGE, 24'hFFFFFF, 12'd0, 13'd0);
		send_request(CMD_PROG_SECTOR, 24'hFFFFFF, 12'd128, 13'd0);
		send_request(CMD_ERASE_SECTOR, 24'h800000, 12'd0, 13'd0);
		send_request(CMD_ERASE_BLOCK, 24'h000100, 12'd0, 13'd0);
		send_request(CMD_ERASE_CHIP, 24'h000000, 12'd0, 13'd0);
		send_request(CMD_UNDEFINED, 24'hFFFFFF, 12'hFFF, 13'd4096);

		// Random phases across both address sizes
		run_random(120, -1);
		wait_drained(8);
		write_addr_mode(1'b0);
		// Long stretch with no idling on either side
		idle_pct = 0;
		stall_pct = 0;
		run_random(120, -1);
		wait_drained(8);
		idle_pct = 11;
		stall_pct = 11;
		write_addr_mode(1'b1);
		run_random(120, 60);
		wait_drained(8);
		write_addr_mode(1'b0);
		run_random(120, -1);
		wait_drained(10);

		$display("covered %0d requests, %0d frames: all commands, rejects, clamped lengths,",
			ledger.requests_seen, ledger.frames_checked);
		$display("page-split sector transfers and both address sizes under random stalls");
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("spi_flash_command_framer_core: match");
		else
			$display("spi_flash_command_framer_core: mismatch");
		$finish;
	end

endmodule
